>>> rtl/core/i2c_register_access_master_macros.svh
// Assertion macros shared by the checker of the I2C register-access master.
// Each macro expands to one labeled concurrent assertion clocked on clk and
// disabled while rst is high.
`ifndef I2C_REGISTER_ACCESS_MASTER_MACROS_SVH
`define I2C_REGISTER_ACCESS_MASTER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define I2CRA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define I2CRA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/i2cra_pkg.sv
package i2cra_pkg;

  localparam int TPU_W   = 10;
  localparam int POLL_W  = 8;
  localparam int DELAY_W = 12;
  localparam int PHASE_W = 4;
  localparam int STAGE_W = 4;
  localparam int BIT_W   = 4;
  localparam int KIND_W  = 3;
  localparam int CFG_IDX_W = 1;

  localparam logic [TPU_W-1:0]  TPU_RESET  = 10'd1;
  localparam logic [POLL_W-1:0] POLL_RESET = 8'd250;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_UNIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_POLL_LIMIT = 1'd1;

  // Command codes.
  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Bus sequencer phases.
  localparam logic [PHASE_W-1:0] PH_IDLE    = 4'd0;
  localparam logic [PHASE_W-1:0] PH_ST_A    = 4'd1;
  localparam logic [PHASE_W-1:0] PH_ST_B    = 4'd2;
  localparam logic [PHASE_W-1:0] PH_SB_SET  = 4'd3;
  localparam logic [PHASE_W-1:0] PH_SB_HIGH = 4'd4;
  localparam logic [PHASE_W-1:0] PH_SB_LOW  = 4'd5;
  localparam logic [PHASE_W-1:0] PH_AK_REL  = 4'd6;
  localparam logic [PHASE_W-1:0] PH_AK_HIGH = 4'd7;
  localparam logic [PHASE_W-1:0] PH_AK_POLL = 4'd8;
  localparam logic [PHASE_W-1:0] PH_RB_LOW  = 4'd9;
  localparam logic [PHASE_W-1:0] PH_RB_HIGH = 4'd10;
  localparam logic [PHASE_W-1:0] PH_NK_LOW  = 4'd11;
  localparam logic [PHASE_W-1:0] PH_NK_HIGH = 4'd12;
  localparam logic [PHASE_W-1:0] PH_SP_LOW  = 4'd13;
  localparam logic [PHASE_W-1:0] PH_SP_HIGH = 4'd14;

  // Kinds of transaction steps.
  localparam logic [KIND_W-1:0] K_START = 3'd0;
  localparam logic [KIND_W-1:0] K_SEND  = 3'd1;
  localparam logic [KIND_W-1:0] K_ACKC  = 3'd2;
  localparam logic [KIND_W-1:0] K_ACKI  = 3'd3;
  localparam logic [KIND_W-1:0] K_RECV  = 3'd4;
  localparam logic [KIND_W-1:0] K_NACK  = 3'd5;
  localparam logic [KIND_W-1:0] K_STOP  = 3'd6;

  localparam logic [STAGE_W-1:0] WR_LEN = 4'd8;
  localparam logic [STAGE_W-1:0] RD_LEN = 4'd11;

  typedef struct packed {
    logic [TPU_W-1:0]  ticks_per_unit;
    logic [POLL_W-1:0] ack_poll_limit;
  } cfg_t;

  typedef struct packed {
    logic [1:0] command;
    logic [6:0] device_addr;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic       sda_in;
  } tick_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_drive_low;
    logic       busy_res;
    logic       done_res;
    logic       nack_error;
    logic [7:0] read_data;
  } result_t;

  function automatic logic [STAGE_W-1:0] plan_len(input logic is_read);
    return is_read ? RD_LEN : WR_LEN;
  endfunction

  // Step kind at position n of the write or read plan; past the end it is a stop.
  function automatic logic [KIND_W-1:0] plan_kind(input logic is_read,
                                                   input logic [STAGE_W-1:0] n);
    logic [KIND_W-1:0] k;
    k = K_STOP;
    if (is_read) begin
      case (n)
        4'd0, 4'd5:        k = K_START;
        4'd1, 4'd3, 4'd6:  k = K_SEND;
        4'd2, 4'd4, 4'd7:  k = K_ACKI;
        4'd8:              k = K_RECV;
        4'd9:              k = K_NACK;
        default:           k = K_STOP;
      endcase
    end else begin
      case (n)
        4'd0:              k = K_START;
        4'd1, 4'd3, 4'd5:  k = K_SEND;
        4'd2, 4'd6:        k = K_ACKC;
        4'd4:              k = K_ACKI;
        default:           k = K_STOP;
      endcase
    end
    return k;
  endfunction

  // Length of a timed phase in ticks: its unit count times the unit length.
  function automatic logic [DELAY_W-1:0] phase_span(input logic [PHASE_W-1:0] ph,
                                                    input logic [TPU_W-1:0] t);
    logic [DELAY_W-1:0] s;
    s = '0;
    unique case (ph)
      PH_AK_REL, PH_AK_HIGH, PH_RB_HIGH:
        s = {2'b00, t};
      PH_SB_SET, PH_SB_HIGH, PH_SB_LOW, PH_RB_LOW, PH_NK_LOW, PH_NK_HIGH:
        s = {1'b0, t, 1'b0};
      PH_ST_A, PH_ST_B, PH_SP_LOW, PH_SP_HIGH:
        s = {t, 2'b00};
      default:
        s = '0;
    endcase
    return s;
  endfunction

  function automatic logic phase_scl(input logic [PHASE_W-1:0] ph);
    logic v;
    v = 1'b1;
    unique case (ph)
      PH_SB_SET, PH_SB_LOW, PH_AK_REL, PH_RB_LOW, PH_NK_LOW, PH_SP_LOW: v = 1'b0;
      default: v = 1'b1;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/core/i2cra_cfg.sv
module i2cra_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [i2cra_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [i2cra_pkg::TPU_W-1:0]     cfg_data,
  output i2cra_pkg::cfg_t                 cfg
);
  import i2cra_pkg::*;

  logic [TPU_W-1:0]  ticks_per_unit;
  logic [POLL_W-1:0] ack_poll_limit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_unit <= TPU_RESET;
      ack_poll_limit <= POLL_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TICKS_PER_UNIT: ticks_per_unit <= cfg_data;
        CFG_ACK_POLL_LIMIT: ack_poll_limit <= cfg_data[POLL_W-1:0];
        default: ;
      endcase
    end
  end

  // A unit length of zero counts as one tick.
  assign cfg.ticks_per_unit = (ticks_per_unit == '0) ? TPU_W'(1) : ticks_per_unit;
  assign cfg.ack_poll_limit = ack_poll_limit;

endmodule

>>> rtl/core/i2cra_seq.sv
module i2cra_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  i2cra_pkg::tick_t    tick,
  input  i2cra_pkg::cfg_t     cfg,
  output i2cra_pkg::result_t  res
);
  import i2cra_pkg::*;

  logic [PHASE_W-1:0] phase, phase_next;
  logic [DELAY_W-1:0] delay_count, delay_count_next;
  logic [BIT_W-1:0]   bit_index, bit_index_next;
  logic [7:0]         shift_byte, shift_byte_next;
  logic [POLL_W-1:0]  poll_count, poll_count_next;
  logic [6:0]         held_device, held_device_next;
  logic [7:0]         held_register, held_register_next;
  logic [7:0]         held_data, held_data_next;
  logic               is_read, is_read_next;
  logic [7:0]         received_byte, received_byte_next;
  logic               error_flag, error_flag_next;
  logic [STAGE_W-1:0] stage, stage_next;
  logic               timed_out, timed_out_next;

  logic               done_now;
  logic               do_begin;
  logic               do_finish;
  logic [STAGE_W-1:0] begin_n;
  logic [DELAY_W-1:0] delay_inc;
  logic [BIT_W-1:0]   bit_inc;
  logic [STAGE_W-1:0] stage_inc;
  logic [7:0]         wr_addr;

  assign delay_inc = delay_count + DELAY_W'(1);
  assign bit_inc   = bit_index + BIT_W'(1);
  assign stage_inc = stage + STAGE_W'(1);

  always_comb begin
    phase_next         = phase;
    delay_count_next   = delay_count;
    bit_index_next     = bit_index;
    shift_byte_next    = shift_byte;
    poll_count_next    = poll_count;
    held_device_next   = held_device;
    held_register_next = held_register;
    held_data_next     = held_data;
    is_read_next       = is_read;
    received_byte_next = received_byte;
    error_flag_next    = error_flag;
    stage_next         = stage;
    timed_out_next     = timed_out;
    do_begin           = 1'b0;
    do_finish          = 1'b0;
    done_now           = 1'b0;
    begin_n            = '0;
    wr_addr            = '0;

    if (phase == PH_IDLE) begin
      if (tick.command == CMD_WRITE || tick.command == CMD_READ) begin
        held_device_next   = tick.device_addr;
        held_register_next = tick.reg_addr;
        held_data_next     = tick.write_data;
        is_read_next       = (tick.command == CMD_READ);
        error_flag_next    = 1'b0;
        timed_out_next     = 1'b0;
        do_begin           = 1'b1;
        begin_n            = '0;
      end
    end else if (phase == PH_AK_POLL) begin
      if (!tick.sda_in) begin
        do_begin = 1'b1;
        begin_n  = stage_inc;
      end else if (poll_count >= cfg.ack_poll_limit) begin
        // Timeout: send a stop right away, the step is resolved after it.
        timed_out_next   = 1'b1;
        phase_next       = PH_SP_LOW;
        delay_count_next = '0;
      end else begin
        poll_count_next = poll_count + POLL_W'(1);
      end
    end else begin
      if (phase == PH_RB_HIGH && delay_count == '0) begin
        shift_byte_next = {shift_byte[6:0], tick.sda_in};
      end
      delay_count_next = delay_inc;
      if (delay_inc >= phase_span(phase, cfg.ticks_per_unit)) begin
        delay_count_next = '0;
        unique case (phase)
          PH_ST_A:    phase_next = PH_ST_B;
          PH_SB_SET:  phase_next = PH_SB_HIGH;
          PH_SB_HIGH: phase_next = PH_SB_LOW;
          PH_SB_LOW: begin
            shift_byte_next = {shift_byte[6:0], 1'b0};
            bit_index_next  = bit_inc;
            if (bit_inc < BIT_W'(8)) begin
              phase_next = PH_SB_SET;
            end else begin
              do_begin = 1'b1;
              begin_n  = stage_inc;
            end
          end
          PH_AK_REL:  phase_next = PH_AK_HIGH;
          PH_AK_HIGH: begin
            poll_count_next = '0;
            phase_next      = PH_AK_POLL;
          end
          PH_RB_LOW:  phase_next = PH_RB_HIGH;
          PH_RB_HIGH: begin
            bit_index_next = bit_inc;
            if (bit_inc < BIT_W'(8)) begin
              phase_next = PH_RB_LOW;
            end else begin
              received_byte_next = shift_byte_next;
              do_begin           = 1'b1;
              begin_n            = stage_inc;
            end
          end
          PH_NK_LOW:  phase_next = PH_NK_HIGH;
          PH_SP_LOW:  phase_next = PH_SP_HIGH;
          PH_SP_HIGH: begin
            if (timed_out) begin
              timed_out_next = 1'b0;
              do_begin       = 1'b1;
              if (plan_kind(is_read, stage) == K_ACKC) begin
                // A checked acknowledge failed: one more stop, then end with error.
                error_flag_next = 1'b1;
                begin_n         = plan_len(is_read) - STAGE_W'(1);
              end else begin
                begin_n = stage_inc;
              end
            end else begin
              do_finish = 1'b1;
            end
          end
          default: begin
            do_begin = 1'b1;
            begin_n  = stage_inc;
          end
        endcase
      end
    end

    if (do_begin) begin
      if (begin_n >= plan_len(is_read_next)) begin
        do_finish = 1'b1;
      end else begin
        stage_next       = begin_n;
        bit_index_next   = '0;
        delay_count_next = '0;
        wr_addr          = {held_device_next, 1'b0};
        unique case (plan_kind(is_read_next, begin_n))
          K_START: phase_next = PH_ST_A;
          K_SEND: begin
            if (begin_n == STAGE_W'(1)) begin
              shift_byte_next = wr_addr;
            end else if (begin_n == STAGE_W'(3)) begin
              shift_byte_next = held_register_next;
            end else if (is_read_next) begin
              shift_byte_next = {wr_addr[7:1], 1'b1};
            end else begin
              shift_byte_next = held_data_next;
            end
            phase_next = PH_SB_SET;
          end
          K_ACKC, K_ACKI: begin
            poll_count_next = '0;
            phase_next      = PH_AK_REL;
          end
          K_RECV: begin
            shift_byte_next = '0;
            phase_next      = PH_RB_LOW;
          end
          K_NACK:  phase_next = PH_NK_LOW;
          default: phase_next = PH_SP_LOW;
        endcase
      end
    end

    if (do_finish) begin
      phase_next       = PH_IDLE;
      delay_count_next = '0;
      stage_next       = '0;
      timed_out_next   = 1'b0;
      done_now         = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      delay_count   <= '0;
      bit_index     <= '0;
      shift_byte    <= '0;
      poll_count    <= '0;
      held_device   <= '0;
      held_register <= '0;
      held_data     <= '0;
      is_read       <= 1'b0;
      received_byte <= '0;
      error_flag    <= 1'b0;
      stage         <= '0;
      timed_out     <= 1'b0;
    end else if (step) begin
      phase         <= phase_next;
      delay_count   <= delay_count_next;
      bit_index     <= bit_index_next;
      shift_byte    <= shift_byte_next;
      poll_count    <= poll_count_next;
      held_device   <= held_device_next;
      held_register <= held_register_next;
      held_data     <= held_data_next;
      is_read       <= is_read_next;
      received_byte <= received_byte_next;
      error_flag    <= error_flag_next;
      stage         <= stage_next;
      timed_out     <= timed_out_next;
    end
  end

  // The result shows the state after this tick.
  always_comb begin
    res.scl_level = phase_scl(phase_next);
    unique case (phase_next)
      PH_ST_B, PH_SP_LOW, PH_SP_HIGH:    res.sda_drive_low = 1'b1;
      PH_SB_SET, PH_SB_HIGH, PH_SB_LOW:  res.sda_drive_low = ~shift_byte_next[7];
      default:                           res.sda_drive_low = 1'b0;
    endcase
    res.busy_res   = (phase_next != PH_IDLE);
    res.done_res   = done_now;
    res.nack_error = error_flag_next;
    res.read_data  = received_byte_next;
  end

endmodule

>>> rtl/core/i2c_register_access_master.sv
// Channel   Direction  Handshake               Beat contents
// input     in         in_valid / in_ready     command, device_addr, reg_addr,
//                                              write_data, sda_in (one bus tick)
// result    out        out_valid / out_ready   scl_level, sda_drive_low, busy_res,
//                                              done_res, nack_error, read_data
// config    in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Each input beat is one tick of the bus sequencer and yields exactly one result beat.
// A beat is held in the input register and is stepped into the result register
// once the result slot is free; with out_ready held high one beat is taken every cycle.
// The rate is set by the sequencer step between those two registers.
// rst is synchronous and active high; it clears the sequencer to idle, sets
// ticks_per_unit to 1 and ack_poll_limit to 250, and empties both registers.
// A stalled result holds its beat while the input register can still take one more.
module i2c_register_access_master (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      command,
  input  logic [6:0]                      device_addr,
  input  logic [7:0]                      reg_addr,
  input  logic [7:0]                      write_data,
  input  logic                            sda_in,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            scl_level,
  output logic                            sda_drive_low,
  output logic                            busy_res,
  output logic                            done_res,
  output logic                            nack_error,
  output logic [7:0]                      read_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [i2cra_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [i2cra_pkg::TPU_W-1:0]     cfg_data
);
  import i2cra_pkg::*;

  cfg_t    cfg;
  tick_t   tick_q;
  logic    tick_valid;
  logic    step;
  result_t res;
  result_t res_q;

  // The sequencer advances when a tick is held and the result slot is free
  // or being drained in this cycle.
  assign step     = tick_valid && (!out_valid || out_ready);
  assign in_ready = !tick_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
    end else if (in_ready) begin
      tick_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      tick_q.command     <= command;
      tick_q.device_addr <= device_addr;
      tick_q.reg_addr    <= reg_addr;
      tick_q.write_data  <= write_data;
      tick_q.sda_in      <= sda_in;
    end
  end

  i2cra_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  i2cra_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .tick (tick_q),
    .cfg  (cfg),
    .res  (res)
  );

  // Result register: loaded on every step, held while the consumer stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign scl_level     = res_q.scl_level;
  assign sda_drive_low = res_q.sda_drive_low;
  assign busy_res      = res_q.busy_res;
  assign done_res      = res_q.done_res;
  assign nack_error    = res_q.nack_error;
  assign read_data     = res_q.read_data;

endmodule

>>> rtl/core/i2cra_checker.sv
`include "i2c_register_access_master_macros.svh"

module i2cra_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       scl_level,
  input logic       sda_drive_low,
  input logic       busy_res,
  input logic       done_res,
  input logic       nack_error,
  input logic [7:0] read_data
);

  // A stalled result beat keeps read_data, scl_level, sda_drive_low and busy_res.
  `I2CRA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(read_data) && $stable(scl_level) && $stable(sda_drive_low) && $stable(busy_res), "result beat changed while stalled")

  // The beat that ends a transaction shows the bus released.
  `I2CRA_ASSERT_NOW(a_done_idle, out_valid && done_res, !busy_res && scl_level && !sda_drive_low, "done beat does not show an idle bus")

  // While idle the bus is released.
  `I2CRA_ASSERT_NOW(a_idle_bus, out_valid && !busy_res, scl_level && !sda_drive_low, "idle beat drives the bus")

  // Once an error is flagged during a transaction only the final stop remains.
  `I2CRA_ASSERT_NOW(a_err_stop, out_valid && busy_res && nack_error, sda_drive_low, "error flagged outside the final stop")

endmodule

bind i2c_register_access_master i2cra_checker u_i2cra_checker (.*);
